[rtl/ihdp_pkg.sv]
// Shared types and constants for the image header dimension parser.
// No dependencies; every other file in rtl refers to this package by scoped name.
`timescale 1ns / 1ps

package ihdp_pkg;

    localparam int ScanLimit = 262144;
    localparam int CountW    = $clog2(ScanLimit + 1);

    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_PNG  = 2'd1;
    localparam logic [1:0] FMT_JPEG = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]  format;
        logic [30:0] width;
        logic [30:0] height;
    } out_t;

    typedef struct packed {
        logic              fire;
        logic              scan;
        logic              last;
        logic [7:0]        data;
        logic [CountW-1:0] pos;
    } step_t;

endpackage

[rtl/ihdp_png.sv]
// PNG signature and IHDR check with width and height capture.
// Depends on ihdp_pkg for the step request type.
`timescale 1ns / 1ps

module ihdp_png (
    input  logic                aclk,
    input  logic                aresetn,
    input  ihdp_pkg::step_t     step,
    output logic                png_ok,
    output logic [31:0]         png_width,
    output logic [31:0]         png_height
);

    localparam logic [7:0] PNG_SIG [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                           8'd13, 8'd10, 8'd26, 8'd10};
    localparam logic [7:0] IHDR_TAG [4] = '{8'h49, 8'h48, 8'h44, 8'h52};

    localparam logic [ihdp_pkg::CountW-1:0] POS_SIG_END  = 8;
    localparam logic [ihdp_pkg::CountW-1:0] POS_TAG_LO   = 12;
    localparam logic [ihdp_pkg::CountW-1:0] POS_WIDTH_LO = 16;
    localparam logic [ihdp_pkg::CountW-1:0] POS_HEIGHT_LO = 20;
    localparam logic [ihdp_pkg::CountW-1:0] POS_END      = 24;

    logic        match_reg;
    logic        match_next;
    logic [31:0] width_reg;
    logic [31:0] width_next;
    logic [31:0] height_reg;
    logic [31:0] height_next;

    always_comb begin
        match_next  = match_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (step.scan) begin
            if (step.pos < POS_SIG_END) begin
                if (step.data != PNG_SIG[step.pos[2:0]]) begin
                    match_next = 1'b0;
                end
            end else if (step.pos >= POS_TAG_LO && step.pos < POS_WIDTH_LO) begin
                if (step.data != IHDR_TAG[step.pos[1:0]]) begin
                    match_next = 1'b0;
                end
            end else if (step.pos >= POS_WIDTH_LO && step.pos < POS_HEIGHT_LO) begin
                width_next = {width_reg[23:0], step.data};
            end else if (step.pos >= POS_HEIGHT_LO && step.pos < POS_END) begin
                height_next = {height_reg[23:0], step.data};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg  <= 1'b1;
            width_reg  <= '0;
            height_reg <= '0;
        end else if (step.fire) begin
            if (step.last) begin
                match_reg  <= 1'b1;
                width_reg  <= '0;
                height_reg <= '0;
            end else begin
                match_reg  <= match_next;
                width_reg  <= width_next;
                height_reg <= height_next;
            end
        end
    end

    assign png_ok = match_next
                    && (width_next != 32'd0) && !width_next[31]
                    && (height_next != 32'd0) && !height_next[31];
    assign png_width  = width_next;
    assign png_height = height_next;

endmodule

[rtl/ihdp_jpeg.sv]
// JPEG marker walker that captures the frame header height and width.
// Depends on ihdp_pkg for the step request type.
`timescale 1ns / 1ps

module ihdp_jpeg (
    input  logic                aclk,
    input  logic                aresetn,
    input  ihdp_pkg::step_t     step,
    output logic                jpeg_found,
    output logic [15:0]         jpeg_width,
    output logic [15:0]         jpeg_height
);

    localparam logic [2:0] PH_SOI0 = 3'd0;
    localparam logic [2:0] PH_SOI1 = 3'd1;
    localparam logic [2:0] PH_HUNT = 3'd2;
    localparam logic [2:0] PH_MARK = 3'd3;
    localparam logic [2:0] PH_LENH = 3'd4;
    localparam logic [2:0] PH_LENL = 3'd5;
    localparam logic [2:0] PH_BODY = 3'd6;

    localparam logic [1:0] OC_UNDECIDED = 2'd0;
    localparam logic [1:0] OC_FOUND     = 2'd1;
    localparam logic [1:0] OC_FAILED    = 2'd2;

    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_STUFF  = 8'h00;
    localparam logic [7:0] MK_TEM    = 8'h01;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_RST_LO = 8'hD0;
    localparam logic [7:0] MK_RST_HI = 8'hD7;
    localparam logic [7:0] MK_SOF_LO = 8'hC0;
    localparam logic [7:0] MK_SOF_HI = 8'hC3;

    logic [2:0]  phase_reg,   phase_next;
    logic [15:0] left_reg,    left_next;
    logic [7:0]  lenhi_reg,   lenhi_next;
    logic        frame_reg,   frame_next;
    logic [15:0] width_reg,   width_next;
    logic [15:0] height_reg,  height_next;
    logic [1:0]  outcome_reg, outcome_next;
    logic [15:0] seg_len;
    logic [7:0]  b;

    assign b       = step.data;
    assign seg_len = {lenhi_reg, b};

    always_comb begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        lenhi_next   = lenhi_reg;
        frame_next   = frame_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        outcome_next = outcome_reg;
        if (step.scan && outcome_reg == OC_UNDECIDED) begin
            case (phase_reg)
                PH_SOI0: begin
                    if (b == MK_PREFIX) begin
                        phase_next = PH_SOI1;
                    end else begin
                        outcome_next = OC_FAILED;
                    end
                end
                PH_SOI1: begin
                    if (b == MK_SOI) begin
                        phase_next = PH_HUNT;
                    end else begin
                        outcome_next = OC_FAILED;
                    end
                end
                PH_HUNT: begin
                    if (b == MK_PREFIX) begin
                        phase_next = PH_MARK;
                    end
                end
                PH_MARK: begin
                    if (b == MK_STUFF || b == MK_SOI || b == MK_TEM
                            || (b >= MK_RST_LO && b <= MK_RST_HI)) begin
                        phase_next = PH_HUNT;
                    end else if (b == MK_EOI || b == MK_SOS) begin
                        outcome_next = OC_FAILED;
                    end else begin
                        frame_next = (b >= MK_SOF_LO) && (b <= MK_SOF_HI);
                        phase_next = PH_LENH;
                    end
                end
                PH_LENH: begin
                    lenhi_next = b;
                    phase_next = PH_LENL;
                end
                PH_LENL: begin
                    if (seg_len < 16'd2 || (frame_reg && seg_len < 16'd7)) begin
                        outcome_next = OC_FAILED;
                    end else begin
                        left_next  = seg_len - 16'd2;
                        lenhi_next = '0;
                        if (frame_reg) begin
                            width_next  = '0;
                            height_next = '0;
                        end
                        phase_next = (seg_len == 16'd2) ? PH_HUNT : PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (frame_reg) begin
                        if (lenhi_reg == 8'd1 || lenhi_reg == 8'd2) begin
                            height_next = {height_reg[7:0], b};
                        end else if (lenhi_reg == 8'd3 || lenhi_reg == 8'd4) begin
                            width_next = {width_reg[7:0], b};
                        end
                    end
                    if (lenhi_reg != 8'hFF) begin
                        lenhi_next = lenhi_reg + 8'd1;
                    end
                    left_next = left_reg - 16'd1;
                    if (left_reg == 16'd1) begin
                        if (frame_reg) begin
                            outcome_next = (width_next != 16'd0 && height_next != 16'd0)
                                           ? OC_FOUND : OC_FAILED;
                        end else begin
                            phase_next = PH_HUNT;
                        end
                    end
                end
                default: begin
                    outcome_next = OC_FAILED;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SOI0;
            left_reg    <= '0;
            lenhi_reg   <= '0;
            frame_reg   <= 1'b0;
            width_reg   <= '0;
            height_reg  <= '0;
            outcome_reg <= OC_UNDECIDED;
        end else if (step.fire) begin
            if (step.last) begin
                phase_reg   <= PH_SOI0;
                left_reg    <= '0;
                lenhi_reg   <= '0;
                frame_reg   <= 1'b0;
                width_reg   <= '0;
                height_reg  <= '0;
                outcome_reg <= OC_UNDECIDED;
            end else begin
                phase_reg   <= phase_next;
                left_reg    <= left_next;
                lenhi_reg   <= lenhi_next;
                frame_reg   <= frame_next;
                width_reg   <= width_next;
                height_reg  <= height_next;
                outcome_reg <= outcome_next;
            end
        end
    end

    assign jpeg_found  = (outcome_next == OC_FOUND);
    assign jpeg_width  = width_next;
    assign jpeg_height = height_next;

endmodule

[rtl/image_header_dimension_parser_unit.sv]
// Top level of the image header dimension parser: input register, PNG and JPEG
// checks, result selection and output register. Depends on ihdp_pkg, ihdp_png, ihdp_jpeg.
`timescale 1ns / 1ps

// Usage
// The s_ channel carries the bytes of a file in order, one request per byte, with
// last_byte set on the final byte. Only the first ScanLimit bytes are examined; later
// bytes are accepted and discarded, though their last_byte flag still ends the file.
// The m_ channel carries one result request per file, giving the format (none, PNG or
// JPEG) and the 31-bit width and height, which are zero when nothing was found.
// Throughput is one byte per cycle while no final byte is held back: the byte accepted
// into the input register is folded into both header checks on the next edge, so the
// input register is free again every cycle. The final byte passes the input register
// and its result the output register on the way to m_. While a result waits on m_ with
// m_ready low, bytes of the next file keep flowing; only a further final byte is held
// in the input register until the waiting result is taken, and s_ready drops behind it.
// After reset both channels are empty and the parser is at the start of a file; it
// returns to that state by itself after every final byte.

module image_header_dimension_parser_unit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ihdp_pkg::in_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ihdp_pkg::out_t   m_data
);

    localparam logic [ihdp_pkg::CountW-1:0] SCAN_END = ihdp_pkg::CountW'(ihdp_pkg::ScanLimit);
    localparam logic [ihdp_pkg::CountW-1:0] PNG_MIN  = 24;
    localparam logic [ihdp_pkg::CountW-1:0] JPEG_MIN = 4;

    logic                        in_valid_reg;
    ihdp_pkg::in_t               in_data_reg;
    logic [ihdp_pkg::CountW-1:0] count_reg;
    logic [ihdp_pkg::CountW-1:0] count_next;
    logic                        m_valid_reg;
    ihdp_pkg::out_t              m_data_reg;
    ihdp_pkg::out_t              result;
    ihdp_pkg::step_t             step;
    logic                        fire;
    logic                        png_ok;
    logic [31:0]                 png_width;
    logic [31:0]                 png_height;
    logic                        jpeg_found;
    logic [15:0]                 jpeg_width;
    logic [15:0]                 jpeg_height;

    assign fire    = in_valid_reg && (!in_data_reg.last_byte || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    assign step.fire = fire;
    assign step.scan = (count_reg < SCAN_END);
    assign step.last = in_data_reg.last_byte;
    assign step.data = in_data_reg.data_byte;
    assign step.pos  = count_reg;

    assign count_next = step.scan ? count_reg + 1'b1 : count_reg;

    ihdp_png u_png (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .png_ok     (png_ok),
        .png_width  (png_width),
        .png_height (png_height)
    );

    ihdp_jpeg u_jpeg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .jpeg_found  (jpeg_found),
        .jpeg_width  (jpeg_width),
        .jpeg_height (jpeg_height)
    );

    always_comb begin
        result = '0;
        if (png_ok && count_next >= PNG_MIN) begin
            result.format = ihdp_pkg::FMT_PNG;
            result.width  = png_width[30:0];
            result.height = png_height[30:0];
        end else if (jpeg_found && count_next >= JPEG_MIN) begin
            result.format = ihdp_pkg::FMT_JPEG;
            result.width  = {15'd0, jpeg_width};
            result.height = {15'd0, jpeg_height};
        end else begin
            result.format = ihdp_pkg::FMT_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                count_reg <= in_data_reg.last_byte ? '0 : count_next;
            end
            if (fire && in_data_reg.last_byte) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire && in_data_reg.last_byte) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/ihdp_checker.sv]
// Port-level assertions for the image header dimension parser, bound to the top level.
// Depends on ihdp_pkg and image_header_dimension_parser_unit.
`timescale 1ns / 1ps

module ihdp_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input ihdp_pkg::in_t    s_data,
    input logic             m_valid,
    input logic             m_ready,
    input ihdp_pkg::out_t   m_data
);

    // A held result must not change until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result request changed while stalled");

    // A fresh result is always preceded by an accepted final byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_data.last_byte, 2))
        else $error("result without a preceding final byte");

    // A failed search reports zero dimensions.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.format == ihdp_pkg::FMT_NONE
            |-> m_data.width == 31'd0 && m_data.height == 31'd0)
        else $error("dimensions reported without a format");

    // A found image never has a zero dimension.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.format == ihdp_pkg::FMT_PNG
                    || m_data.format == ihdp_pkg::FMT_JPEG)
            |-> m_data.width != 31'd0 && m_data.height != 31'd0)
        else $error("zero dimension reported as found");

    // JPEG frame dimensions are 16 bits wide.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.format == ihdp_pkg::FMT_JPEG
            |-> m_data.width[30:16] == 15'd0 && m_data.height[30:16] == 15'd0)
        else $error("JPEG dimension wider than 16 bits");

endmodule

bind image_header_dimension_parser_unit ihdp_checker u_ihdp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
